@@ rtl/core/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Holds the request and result payload types, the operation and status codes,
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Default number of ring entries.
  localparam int DEPTH_DEFAULT = 16;

  // Width of the reported fill count.
  localparam int FILL_W = 5;

  // Operation codes.
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One request.
  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [31:0] push_value;
  } req_t;

  // One result.
  typedef struct packed {
    logic signed [31:0]       popped_value;
    logic        [1:0]        status;
    logic        [FILL_W-1:0] fill_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // carry out the accepted request
    logic load_read;  // capture the read data into the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_read;   // the waiting request is a pop that will read the ring
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/dq_ram.sv @@
// ----------------------------------------------------------------------------
// dq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath: ring pointers, entry store and result register
// Keeps the head index and entry count, works out ring addresses, drives the
// entry RAM and assembles the result for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire dq_pkg::req_t req_data,
  input  wire dq_pkg::cmd_t cmd,
  output dq_pkg::stat_t     stat,
  output dq_pkg::rsp_t      rsp_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          is_push;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] back_push_pos;
  logic [AW-1:0] back_pop_pos;
  logic [CW-1:0] count_dec;
  logic [1:0]    status_code;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  // Position that lies a given offset past the base, wrapped around the ring.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // Decode the waiting request against the current fill state.
  assign is_push       = (req_data.operation == dq_pkg::OP_PUSH_FRONT) ||
                         (req_data.operation == dq_pkg::OP_PUSH_BACK);
  assign full          = (count == FULL_CNT);
  assign empty         = (count == '0);
  assign count_dec     = count - CW'(1);
  assign head_dec      = (head == '0) ? LAST_IDX : head - AW'(1);
  assign back_push_pos = ring_pos(head, count[AW-1:0]);
  assign back_pop_pos  = ring_pos(head, count_dec[AW-1:0]);

  assign stat.pop_read = !is_push && !empty;

  // Next pointer state, RAM access and status for the executed request.
  always_comb begin
    head_next   = head;
    count_next  = count;
    status_code = dq_pkg::ST_OK;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = back_push_pos;
    rd_addr     = head;
    if (is_push) begin
      if (full) begin
        status_code = dq_pkg::ST_FULL;
      end else begin
        wr_en      = cmd.exec;
        count_next = count + CW'(1);
        if (req_data.operation == dq_pkg::OP_PUSH_FRONT) begin
          wr_addr   = head_dec;
          head_next = head_dec;
        end
      end
    end else begin
      if (empty) begin
        status_code = dq_pkg::ST_EMPTY;
      end else begin
        rd_en      = cmd.exec;
        count_next = count_dec;
        if (req_data.operation == dq_pkg::OP_POP_FRONT) begin
          head_next = ring_pos(head, AW'(1));
        end else begin
          rd_addr = back_pop_pos;
        end
      end
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Result register: status and count at execution, popped data in the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_data.popped_value <= '0;
      rsp_data.status       <= status_code;
      rsp_data.fill_count   <= dq_pkg::FILL_W'(count_next);
    end else if (cmd.load_read) begin
      rsp_data.popped_value <= $signed(rd_data);
    end
  end

  // Entry store.
  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_data.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The count never goes past the ring size and the head stays inside it.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= FULL_CNT) && ({1'b0, head} < DEPTH_W))
    else $error("deque count or head out of range");

  // An accepted push with room raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && !full) |=> (count == $past(count) + CW'(1)))
    else $error("push did not raise the count");

  // A refused request leaves the pointers alone.
  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && ((is_push && full) || (!is_push && empty))) |=>
      ((count == $past(count)) && (head == $past(head))))
    else $error("refused request changed the pointers");

endmodule

`default_nettype wire

@@ rtl/core/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer for the double-ended queue
// Takes one request at a time, waits out the RAM read for pops, and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  input  wire dq_pkg::stat_t stat,
  output dq_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_stall     = (state != S_IDLE);
  assign rsp_valid     = (state == S_OUT);
  assign accept        = req_valid && (state == S_IDLE);
  assign cmd.exec      = accept;
  assign cmd.load_read = (state == S_READ);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = stat.pop_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A pop that reads the ring always gets its data before the result shows.
  a_read_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_OUT))
    else $error("read cycle not followed by result");

  // A request is never taken while a result is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && (rsp_valid || cmd.load_read)))
    else $error("request taken while busy");

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit signed values in a ring RAM
//
// Requests arrive on req_valid/req_stall/req_data; each carries an operation
// (push front, push back, pop front, pop back) and a value for pushes. Every
// request gives exactly one result on rsp_valid/rsp_stall/rsp_data: the value
// removed by a successful pop (zero otherwise), a status (ok, pop on empty,
// push on full) and the fill count after the operation.
// A request is taken when req_valid is high and req_stall is low; the same
// rule holds for results on the output side.
// After acceptance, pushes and refused requests go straight to the result
// state; pops that read the ring first wait in a read state, set by the RAM's
// registered read port. One request is in flight at a time, so a new request
// is taken only after the receiver has taken the last result.
// While rsp_stall is high the result is held and req_stall stays high.
// Reset (rst, synchronous) empties the queue at once; stored data is not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire dq_pkg::req_t req_data,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output dq_pkg::rsp_t      rsp_data
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  // Sequencer.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Pointers, ring store and result register.
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_data (rsp_data)
  );

endmodule

`default_nettype wire
